// ----- hdl/hsbd_pkg.sv -----
// shared types, constants and helpers for the half-size box downscaler
// used by every module of the block; depends on nothing
package hsbd_pkg;

  localparam int MAX_WIDTH   = 4096;
  localparam int MAX_HEIGHT  = 4096;
  localparam int STORE_DEPTH = MAX_WIDTH / 2;

  localparam int CH_W   = 16;
  localparam int PIX_W  = 4 * CH_W;
  localparam int DIM_W  = 13;
  localparam int CNT_W  = 12;
  localparam int IDX_W  = $clog2(STORE_DEPTH);

  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // register index as decoded from paddr[2]
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(1920);
  localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(1080);

  // request from front to back: a line store write or an emit
  typedef struct packed {
    logic             is_emit;
    logic [IDX_W-1:0] idx;
    logic [PIX_W-1:0] pair;
    logic             row_end;
    logic             frame_end;
  } cmd_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             row_end;
    logic             frame_end;
  } out_t;

  // per-channel truncating average of two packed rgba words
  function automatic logic [PIX_W-1:0] avg_pix(input logic [PIX_W-1:0] a,
                                               input logic [PIX_W-1:0] b);
    logic [PIX_W-1:0] r;
    logic [CH_W:0]    s;
    r = '0;
    for (int c = 0; c < 4; c++) begin
      s = {1'b0, a[c*CH_W +: CH_W]} + {1'b0, b[c*CH_W +: CH_W]};
      r[c*CH_W +: CH_W] = s[CH_W:1];
    end
    return r;
  endfunction

endpackage

// ----- hdl/hsbd_front.sv -----
// front end: raster position counters, horizontal pair average and
// classification of each pixel; depends on hsbd_pkg
module hsbd_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  logic [hsbd_pkg::PIX_W-1:0] pix_i,
  input  logic [hsbd_pkg::DIM_W-1:0] frame_width_i,
  input  logic [hsbd_pkg::DIM_W-1:0] frame_height_i,
  output logic                      cmd_valid_o,
  output hsbd_pkg::cmd_t            cmd_o
);

  logic [hsbd_pkg::CNT_W-1:0] col_q, col_d, row_q, row_d;
  logic [hsbd_pkg::PIX_W-1:0] pair_left_q;
  logic [hsbd_pkg::DIM_W-1:0] w_eff, h_eff, w_even, h_even;
  logic [hsbd_pkg::DIM_W-1:0] col_inc, row_inc;
  logic [hsbd_pkg::CNT_W-1:0] half_last;
  logic                       pair_done, last_row;

  always_comb begin
    if (frame_width_i == '0) w_eff = hsbd_pkg::DIM_W'(1);
    else if (frame_width_i > hsbd_pkg::DIM_W'(hsbd_pkg::MAX_WIDTH))
      w_eff = hsbd_pkg::DIM_W'(hsbd_pkg::MAX_WIDTH);
    else w_eff = frame_width_i;
    if (frame_height_i == '0) h_eff = hsbd_pkg::DIM_W'(1);
    else if (frame_height_i > hsbd_pkg::DIM_W'(hsbd_pkg::MAX_HEIGHT))
      h_eff = hsbd_pkg::DIM_W'(hsbd_pkg::MAX_HEIGHT);
    else h_eff = frame_height_i;
  end

  assign w_even    = {w_eff[hsbd_pkg::DIM_W-1:1], 1'b0};
  assign h_even    = {h_eff[hsbd_pkg::DIM_W-1:1], 1'b0};
  assign half_last = w_eff[hsbd_pkg::DIM_W-1:1] - hsbd_pkg::CNT_W'(1);

  assign pair_done = col_q[0] && ({1'b0, col_q} < w_even) && ({1'b0, row_q} < h_eff);
  assign last_row  = ({1'b0, row_q} < h_even);

  always_comb begin
    cmd_o.is_emit   = row_q[0];
    cmd_o.idx       = col_q[hsbd_pkg::CNT_W-1:1];
    cmd_o.pair      = hsbd_pkg::avg_pix(pair_left_q, pix_i);
    cmd_o.row_end   = ({1'b0, cmd_o.idx} == half_last);
    cmd_o.frame_end = cmd_o.row_end && ({1'b0, row_q} == h_even - hsbd_pkg::DIM_W'(1));
    // odd rows below the even height emit, even rows write the store
    cmd_valid_o     = accept_i && pair_done && (!row_q[0] || last_row);
  end

  always_comb begin
    col_inc = {1'b0, col_q} + hsbd_pkg::DIM_W'(1);
    row_inc = {1'b0, row_q} + hsbd_pkg::DIM_W'(1);
    col_d   = col_q;
    row_d   = row_q;
    if (accept_i) begin
      if (col_inc >= w_eff) begin
        col_d = '0;
        row_d = (row_inc >= h_eff) ? '0 : row_inc[hsbd_pkg::CNT_W-1:0];
      end else begin
        col_d = col_inc[hsbd_pkg::CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      pair_left_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (accept_i && !col_q[0]) begin
        pair_left_q <= pix_i;
      end
    end
  end

endmodule

// ----- hdl/hsbd_cmd_fifo.sv -----
// short request queue between front and back end
// depends on hsbd_pkg
module hsbd_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  hsbd_pkg::cmd_t data_i,
  input  logic           pop_i,
  output hsbd_pkg::cmd_t data_o,
  output logic           empty_o,
  output logic           full_o
);

  hsbd_pkg::cmd_t                  entry_q [hsbd_pkg::CMDQ_DEPTH];
  logic [hsbd_pkg::CMDQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [hsbd_pkg::CMDQ_CNT_W-1:0] cnt_q;
  logic                            do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == hsbd_pkg::CMDQ_CNT_W'(hsbd_pkg::CMDQ_DEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + hsbd_pkg::CMDQ_PTR_W'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + hsbd_pkg::CMDQ_PTR_W'(1);
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + hsbd_pkg::CMDQ_CNT_W'(1);
        2'b01:   cnt_q <= cnt_q - hsbd_pkg::CMDQ_CNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ----- hdl/hsbd_back.sv -----
// back end: line store, vertical average and result queue
// depends on hsbd_pkg
module hsbd_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cmd_valid_i,
  input  hsbd_pkg::cmd_t             cmd_i,
  output logic                       cmd_pop_o,
  input  logic                       pop_i,
  output logic                       empty_o,
  output hsbd_pkg::out_t             out_o
);

  logic [hsbd_pkg::PIX_W-1:0] row_store [hsbd_pkg::STORE_DEPTH];
  logic [hsbd_pkg::PIX_W-1:0] rd_data_q;

  logic                       s1_valid_q;
  logic [hsbd_pkg::PIX_W-1:0] s1_pair_q;
  logic                       s1_row_end_q, s1_frame_end_q;

  hsbd_pkg::out_t                  outq_q [hsbd_pkg::OUTQ_DEPTH];
  logic [hsbd_pkg::OUTQ_PTR_W-1:0] owr_ptr_q, ord_ptr_q;
  logic [hsbd_pkg::OUTQ_CNT_W-1:0] ocnt_q, committed;
  logic                            has_space, wr_store, rd_store, out_pop;

  // results in the queue plus the one whose store read is in flight
  assign committed = ocnt_q + hsbd_pkg::OUTQ_CNT_W'(s1_valid_q);
  assign has_space = committed < hsbd_pkg::OUTQ_CNT_W'(hsbd_pkg::OUTQ_DEPTH);
  assign cmd_pop_o = cmd_valid_i && (!cmd_i.is_emit || has_space);
  assign wr_store  = cmd_pop_o && !cmd_i.is_emit;
  assign rd_store  = cmd_pop_o && cmd_i.is_emit;

  assign empty_o = (ocnt_q == '0);
  assign out_pop = pop_i && !empty_o;
  assign out_o   = outq_q[ord_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_store) begin
      row_store[cmd_i.idx] <= cmd_i.pair;
    end
    if (rd_store) begin
      rd_data_q <= row_store[cmd_i.idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_store) begin
      s1_pair_q      <= cmd_i.pair;
      s1_row_end_q   <= cmd_i.row_end;
      s1_frame_end_q <= cmd_i.frame_end;
    end
    if (s1_valid_q) begin
      outq_q[owr_ptr_q].pix       <= hsbd_pkg::avg_pix(rd_data_q, s1_pair_q);
      outq_q[owr_ptr_q].row_end   <= s1_row_end_q;
      outq_q[owr_ptr_q].frame_end <= s1_frame_end_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      owr_ptr_q  <= '0;
      ord_ptr_q  <= '0;
      ocnt_q     <= '0;
    end else begin
      s1_valid_q <= rd_store;
      if (s1_valid_q) owr_ptr_q <= owr_ptr_q + hsbd_pkg::OUTQ_PTR_W'(1);
      if (out_pop)    ord_ptr_q <= ord_ptr_q + hsbd_pkg::OUTQ_PTR_W'(1);
      unique case ({s1_valid_q, out_pop})
        2'b10:   ocnt_q <= ocnt_q + hsbd_pkg::OUTQ_CNT_W'(1);
        2'b01:   ocnt_q <= ocnt_q - hsbd_pkg::OUTQ_CNT_W'(1);
        default: ocnt_q <= ocnt_q;
      endcase
    end
  end

endmodule

// ----- hdl/half_size_box_downscale.sv -----
// half-size box downscale: apb registers and the front/back pipeline
// depends on hsbd_pkg, hsbd_front, hsbd_cmd_fifo and hsbd_back
//
// 2x2 box downscale of a raster stream of 16-bit rgba pixels. one pixel
// is taken per clock (push while full is low); full rises only when the
// four-deep request queue between front and back backs up, which in turn
// happens only when the result side is not popped. the edge that accepts
// the pixel completing a result queues the request; the back reads the
// line store (one read/write port, 2048 x 64 bits) once the request is at
// the queue head and the result queue has room; a further edge puts the
// vertical average into a four-deep result queue. the horizontal pair is
// averaged with truncation, even rows fill the line store, odd rows average
// again (truncating) with the stored pair and emit one pixel. odd widths drop
// the last column, odd heights the last row. row_end and frame_end mark the
// last pixel of an output row and of the frame. the user must write
// frame_width (addr 0) and frame_height (addr 4) over apb only while the
// block is idle; the block does not enforce this. zero is taken as one
// and values above 4096 as 4096. the line store needs no clearing pass after reset.
module half_size_box_downscale (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // pixel input queue side
  input  logic                          push,
  output logic                          full,
  input  logic [hsbd_pkg::CH_W-1:0]     red_i,
  input  logic [hsbd_pkg::CH_W-1:0]     green_i,
  input  logic [hsbd_pkg::CH_W-1:0]     blue_i,
  input  logic [hsbd_pkg::CH_W-1:0]     alpha_i,
  // result queue side
  output logic                          empty,
  input  logic                          pop,
  output logic [hsbd_pkg::CH_W-1:0]     out_red_o,
  output logic [hsbd_pkg::CH_W-1:0]     out_green_o,
  output logic [hsbd_pkg::CH_W-1:0]     out_blue_o,
  output logic [hsbd_pkg::CH_W-1:0]     out_alpha_o,
  output logic                          row_end_o,
  output logic                          frame_end_o,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hsbd_pkg::PADDR_W-1:0]  paddr,
  input  logic [hsbd_pkg::PDATA_W-1:0]  pwdata,
  output logic [hsbd_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  logic [hsbd_pkg::DIM_W-1:0] frame_width_q, frame_height_q;
  logic                       cfg_write, in_accept;
  logic                       cmd_push, cmd_pop, cmd_empty;
  hsbd_pkg::cmd_t             cmd_in, cmd_head;
  hsbd_pkg::out_t             res;
  logic [hsbd_pkg::PIX_W-1:0] pix_in;

  // register access, no wait states
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= hsbd_pkg::WIDTH_RESET;
      frame_height_q <= hsbd_pkg::HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        hsbd_pkg::REG_FRAME_WIDTH:  frame_width_q  <= pwdata[hsbd_pkg::DIM_W-1:0];
        hsbd_pkg::REG_FRAME_HEIGHT: frame_height_q <= pwdata[hsbd_pkg::DIM_W-1:0];
        default:                    frame_width_q  <= frame_width_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      hsbd_pkg::REG_FRAME_WIDTH:
        prdata = hsbd_pkg::PDATA_W'(frame_width_q);
      hsbd_pkg::REG_FRAME_HEIGHT:
        prdata = hsbd_pkg::PDATA_W'(frame_height_q);
      default:
        prdata = '0;
    endcase
  end

  // an accepted pixel always advances the counters; only pair completions
  // produce a request
  assign in_accept = push && !full;
  assign pix_in    = {alpha_i, blue_i, green_i, red_i};

  hsbd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (in_accept),
    .pix_i          (pix_in),
    .frame_width_i  (frame_width_q),
    .frame_height_i (frame_height_q),
    .cmd_valid_o    (cmd_push),
    .cmd_o          (cmd_in)
  );

  // decouples the pixel stream from stalls on the result side
  hsbd_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .pop_i   (cmd_pop),
    .data_o  (cmd_head),
    .empty_o (cmd_empty),
    .full_o  (full)
  );

  hsbd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!cmd_empty),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (cmd_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_o       (res)
  );

  // result fields, channel order matches the packed pixel word
  assign out_red_o   = res.pix[0*hsbd_pkg::CH_W +: hsbd_pkg::CH_W];
  assign out_green_o = res.pix[1*hsbd_pkg::CH_W +: hsbd_pkg::CH_W];
  assign out_blue_o  = res.pix[2*hsbd_pkg::CH_W +: hsbd_pkg::CH_W];
  assign out_alpha_o = res.pix[3*hsbd_pkg::CH_W +: hsbd_pkg::CH_W];
  assign row_end_o   = res.row_end;
  assign frame_end_o = res.frame_end;

endmodule

// ----- hdl/hsbd_checker.sv -----
// port-level checks of the half-size box downscaler, bound to the top level
// depends on hsbd_pkg and half_size_box_downscale
module hsbd_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         empty,
  input logic                         pop,
  input logic [hsbd_pkg::CH_W-1:0]    out_red_o,
  input logic                         row_end_o,
  input logic                         frame_end_o,
  input logic                         psel,
  input logic                         penable,
  input logic                         pwrite,
  input logic [hsbd_pkg::PADDR_W-1:0] paddr,
  input logic [hsbd_pkg::PDATA_W-1:0] pwdata,
  input logic [hsbd_pkg::PDATA_W-1:0] prdata,
  input logic                         pready
);

  // the frame ends on the last pixel of a row
  a_frame_end_on_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && frame_end_o) |-> row_end_o)
    else $error("frame_end without row_end");

  // a waiting result stays put until taken
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_red_o) && $stable(row_end_o)))
    else $error("result changed while waiting");

  // a width write reads back on the next cycle
  a_width_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready && !paddr[2]) |=>
      (!psel || pwrite || paddr[2] ||
       prdata[hsbd_pkg::DIM_W-1:0] == $past(pwdata[hsbd_pkg::DIM_W-1:0])))
    else $error("frame_width readback mismatch");

  // registers are narrower than the data bus
  a_prdata_upper_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel |-> (prdata[hsbd_pkg::PDATA_W-1:hsbd_pkg::DIM_W] == '0))
    else $error("prdata upper bits set");

endmodule

bind half_size_box_downscale hsbd_checker u_hsbd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .empty       (empty),
  .pop         (pop),
  .out_red_o   (out_red_o),
  .row_end_o   (row_end_o),
  .frame_end_o (frame_end_o),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite),
  .paddr       (paddr),
  .pwdata      (pwdata),
  .prdata      (prdata),
  .pready      (pready)
);
